// ----- hw/rtl/brb_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// brb_pkg
// Shared types and codes of the byte ring buffer with block writes.
// ============================================================================
package brb_pkg;

    localparam int CFG_W       = 11;
    localparam int LEN_W       = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_READ = 1'b1
    } t_back_state;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [7:0]        data;
        logic              start;
        logic [LEN_W-1:0]  length;
    } t_cmd;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [7:0]        data;
        logic              byte_valid;
        logic [LEN_W-1:0]  amount;
        logic              last;
    } t_result;

endpackage

// ----- hw/rtl/brb_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// brb_front
// Accepts items, drops unknown actions and turns each item into a command.
// ============================================================================
module brb_front import brb_pkg::*; #(
    parameter int MAX_READ = 64
) (
    input  logic              i_start,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_data_byte,
    input  logic              i_block_start,
    input  logic [LEN_W-1:0]  i_length,
    input  logic              i_queue_full,
    output logic              o_busy,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [LEN_W-1:0] rd_len;
    logic             known;

    assign o_busy = i_queue_full;
    assign rd_len = (i_length > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : i_length;

    always_comb begin
        known        = 1'b1;
        o_cmd.kind   = CMD_WRITE;
        o_cmd.data   = i_data_byte;
        o_cmd.start  = i_block_start;
        o_cmd.length = i_length;
        unique case (t_action'(i_action))
            ACT_WRITE: begin
                o_cmd.kind = CMD_WRITE;
            end
            ACT_READ: begin
                o_cmd.kind   = CMD_READ;
                o_cmd.length = rd_len;
            end
            ACT_CLEAR: begin
                o_cmd.kind = CMD_CLEAR;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign o_push = i_start && !i_queue_full && known;

endmodule

// ----- hw/rtl/brb_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// brb_queue
// Short command queue between the front and the back.
// ============================================================================
module brb_queue import brb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    input  logic  i_pop,
    output t_cmd  o_cmd,
    output logic  o_empty,
    output logic  o_full
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wa;
    logic [QUEUE_AW-1:0] r_ra;
    logic [QUEUE_AW:0]   r_cnt;
    logic [QUEUE_AW-1:0] n_wa;
    logic [QUEUE_AW-1:0] n_ra;
    logic [QUEUE_AW:0]   n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_ra];

    always_comb begin
        n_wa  = i_push ? r_wa + 1'b1 : r_wa;
        n_ra  = i_pop ? r_ra + 1'b1 : r_ra;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wa] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa  <= '0;
            r_ra  <= '0;
            r_cnt <= '0;
        end else begin
            r_wa  <= n_wa;
            r_ra  <= n_ra;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- hw/rtl/brb_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// brb_back
// Executes commands on the ring: byte store, pointers, count and results.
// ============================================================================
module brb_back import brb_pkg::*; #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output t_result           o_res
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int RLEN_W  = $clog2(MAX_READ + 1);
    localparam int CAP_RST = (DEPTH < 1024) ? DEPTH : 1024;

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_mem_q;
    t_back_state       r_state;
    t_back_state       n_state;
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  n_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W-1:0]  n_rp;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_drop;
    logic              n_drop;
    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  n_cap;
    logic [RLEN_W-1:0] r_rem;
    logic [RLEN_W-1:0] n_rem;
    logic [RLEN_W-1:0] r_n;
    logic [RLEN_W-1:0] n_n;
    t_result           r_p;
    t_result           n_p;
    logic              r_p_rd;
    logic              n_p_rd;
    t_result           r_o;
    t_result           n_o;

    logic              mem_we;
    logic              mem_re;
    logic [CNT_W-1:0]  wp_inc;
    logic [CNT_W-1:0]  rp_inc;
    logic [PTR_W-1:0]  wp_adv;
    logic [PTR_W-1:0]  rp_adv;
    logic              wr_fit;
    logic              wr_drop;
    logic [RLEN_W-1:0] rd_len;
    logic [RLEN_W-1:0] rd_n;

    assign wp_inc  = CNT_W'(r_wp) + CNT_W'(1);
    assign rp_inc  = CNT_W'(r_rp) + CNT_W'(1);
    assign wp_adv  = (wp_inc >= r_cap) ? '0 : wp_inc[PTR_W-1:0];
    assign rp_adv  = (rp_inc >= r_cap) ? '0 : rp_inc[PTR_W-1:0];
    assign wr_fit  = (SUM_W'(r_count) + SUM_W'(i_cmd.length)) <= SUM_W'(r_cap);
    assign wr_drop = (i_cmd.start ? !wr_fit : r_drop) || (r_count >= r_cap);
    assign rd_len  = i_cmd.length[RLEN_W-1:0];
    assign rd_n    = (SUM_W'(rd_len) > SUM_W'(r_count)) ? RLEN_W'(r_count) : rd_len;

    always_comb begin
        if (!i_cfg_we) begin
            n_cap = r_cap;
        end else if (i_cfg_wdata == '0) begin
            n_cap = CNT_W'(1);
        end else if (SUM_W'(i_cfg_wdata) > SUM_W'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = CNT_W'(i_cfg_wdata);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty && i_cmd.kind == CMD_READ && rd_n > RLEN_W'(1)) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (r_rem == RLEN_W'(1)) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        n_drop  = r_drop;
        n_rem   = r_rem;
        n_n     = r_n;
        n_p     = '0;
        n_p_rd  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    n_p.valid = 1'b1;
                    n_p.last  = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_WRITE: begin
                            n_drop = wr_drop;
                            if (wr_drop) begin
                                n_p.status = ST_NOSPACE;
                            end else begin
                                mem_we     = 1'b1;
                                n_wp       = wp_adv;
                                n_count    = r_count + CNT_W'(1);
                                n_p.status = ST_OK;
                                n_p.amount = i_cmd.start ? i_cmd.length : '0;
                            end
                        end
                        CMD_READ: begin
                            if (rd_n == '0) begin
                                n_p.status = ST_EMPTY;
                            end else begin
                                mem_re         = 1'b1;
                                n_rp           = rp_adv;
                                n_count        = r_count - CNT_W'(rd_n);
                                n_n            = rd_n;
                                n_rem          = rd_n - RLEN_W'(1);
                                n_p_rd         = 1'b1;
                                n_p.status     = ST_OK;
                                n_p.byte_valid = 1'b1;
                                n_p.amount     = LEN_W'(rd_n);
                                n_p.last       = (rd_n == RLEN_W'(1));
                            end
                        end
                        CMD_CLEAR: begin
                            n_wp       = '0;
                            n_rp       = '0;
                            n_count    = '0;
                            n_drop     = 1'b0;
                            n_p.status = ST_OK;
                        end
                        default: begin
                            n_p.valid = 1'b0;
                        end
                    endcase
                end
            end
            BK_READ: begin
                mem_re         = 1'b1;
                n_rp           = rp_adv;
                n_rem          = r_rem - RLEN_W'(1);
                n_p_rd         = 1'b1;
                n_p.valid      = 1'b1;
                n_p.status     = ST_OK;
                n_p.byte_valid = 1'b1;
                n_p.amount     = LEN_W'(r_n);
                n_p.last       = (r_rem == RLEN_W'(1));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_o = r_p;
        if (r_p_rd) begin
            n_o.data = r_mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= i_cmd.data;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_cap   <= CNT_W'(CAP_RST);
            r_rem   <= '0;
            r_n     <= '0;
            r_p     <= '0;
            r_p_rd  <= 1'b0;
            r_o     <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_cap   <= n_cap;
            r_rem   <= n_rem;
            r_n     <= n_n;
            r_p     <= n_p;
            r_p_rd  <= n_p_rd;
            r_o     <= n_o;
        end
    end

    assign o_res = r_o;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Stored count exceeds the ring depth.");

    a_read_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_READ |-> r_rem != '0)
        else $error("Read run active with no bytes remaining.");

    a_read_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_READ |-> !o_pop)
        else $error("Command popped during a read run.");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o.valid && r_o.byte_valid |-> r_o.status == ST_OK && r_o.amount != '0)
        else $error("Read byte transfer with a bad status or amount.");

endmodule

// ----- hw/rtl/byte_ring_buffer_block_write.sv -----
`timescale 1ns / 1ps
// ============================================================================
// byte_ring_buffer_block_write
// Byte ring buffer with all-or-nothing block writes and capped reads.
// ============================================================================
// Result path: an accepted item passes the command queue, then the r_p and
// r_o result registers.
// Back unit: writes, clears and empty reads finish when popped; a read of n
// bytes makes one store read port access per byte, with no pop until done.
// Reset: synchronous; pointers, count and drop flag clear, capacity goes to
// 1024 (clamped to DEPTH); the byte store keeps its contents.
module byte_ring_buffer_block_write import brb_pkg::*; #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_data_byte,
    input  logic              i_block_start,
    input  logic [LEN_W-1:0]  i_length,
    output logic              o_res_strobe,
    output logic [1:0]        o_status,
    output logic [7:0]        o_data_byte_res,
    output logic              o_byte_valid,
    output logic [LEN_W-1:0]  o_amount,
    output logic              o_last
);

    logic    push;
    logic    pop;
    logic    q_empty;
    logic    q_full;
    t_cmd    front_cmd;
    t_cmd    back_cmd;
    t_result res;

    brb_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .i_start       (i_start),
        .i_action      (i_action),
        .i_data_byte   (i_data_byte),
        .i_block_start (i_block_start),
        .i_length      (i_length),
        .i_queue_full  (q_full),
        .o_busy        (o_busy),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    brb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (back_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    brb_back #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (q_empty),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .o_res       (res)
    );

    assign o_res_strobe    = res.valid;
    assign o_status        = res.status;
    assign o_data_byte_res = res.data;
    assign o_byte_valid    = res.byte_valid;
    assign o_amount        = res.amount;
    assign o_last          = res.last;

endmodule
